/* hdl/bps_pkg.sv */
package bps_pkg;

  // op codes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_DONE   = 2'd1;
  localparam logic [1:0] OP_REBOOT = 2'd2;
  localparam logic [1:0] OP_BEGIN  = 2'd3;

  // phases
  localparam logic [2:0] PH_SETTLE = 3'd0;
  localparam logic [2:0] PH_PREP   = 3'd1;
  localparam logic [2:0] PH_CHARGE = 3'd2;
  localparam logic [2:0] PH_HOST   = 3'd3;
  localparam logic [2:0] PH_RUN    = 3'd4;
  localparam logic [2:0] PH_SDW    = 3'd5;
  localparam logic [2:0] PH_OFF    = 3'd6;

  // actions
  localparam logic [3:0] AC_NONE  = 4'd0;
  localparam logic [3:0] AC_PREP  = 4'd1;
  localparam logic [3:0] AC_ENCH  = 4'd2;
  localparam logic [3:0] AC_STOP  = 4'd3;
  localparam logic [3:0] AC_ARM   = 4'd4;
  localparam logic [3:0] AC_HOST  = 4'd5;
  localparam logic [3:0] AC_PING  = 4'd6;
  localparam logic [3:0] AC_SDREQ = 4'd7;
  localparam logic [3:0] AC_CUT   = 4'd8;

  // shutdown reasons
  localparam logic [1:0] RS_NONE   = 2'd0;
  localparam logic [1:0] RS_MAIN   = 2'd1;
  localparam logic [1:0] RS_REBOOT = 2'd2;

  // issue bit masks
  localparam logic [16:0] IS_STATUS  = 17'h00001;
  localparam logic [16:0] IS_VOLT    = 17'h00002;
  localparam logic [16:0] IS_PREPF   = 17'h00004;
  localparam logic [16:0] IS_ENF     = 17'h00008;
  localparam logic [16:0] IS_CHFAULT = 17'h00010;
  localparam logic [16:0] IS_NORISE  = 17'h00020;
  localparam logic [16:0] IS_STOPF   = 17'h00040;
  localparam logic [16:0] IS_ARMF    = 17'h00080;
  localparam logic [16:0] IS_HOSTF   = 17'h00100;
  localparam logic [16:0] IS_PINGF   = 17'h00200;
  localparam logic [16:0] IS_SDREQF  = 17'h00400;
  localparam logic [16:0] IS_OFFF    = 17'h00800;
  localparam logic [16:0] IS_TIMEOUT = 17'h01000;
  localparam logic [16:0] IS_BOOSTTO = 17'h02000;
  localparam logic [16:0] IS_OVERV   = 17'h04000;
  localparam logic [16:0] IS_TLIMIT  = 17'h08000;
  localparam logic [16:0] IS_NOMAIN  = 17'h10000;

  // register indexes
  localparam logic [2:0] REG_SD_WINDOW  = 3'd0;
  localparam logic [2:0] REG_ACT_TMO    = 3'd1;
  localparam logic [2:0] REG_CHG_LIMIT  = 3'd2;
  localparam logic [2:0] REG_NO_RISE    = 3'd3;
  localparam logic [2:0] REG_MAX_V      = 3'd4;
  localparam logic [2:0] REG_TARGET_V   = 3'd5;
  localparam logic [2:0] REG_RISE_STEP  = 3'd6;
  localparam logic [2:0] REG_ARM_V      = 3'd7;

  localparam int unsigned SETTLING_MS_DEF        = 32'd10000;
  localparam int unsigned PREPARE_TIMEOUT_MS_DEF = 32'd30000;
  localparam int unsigned BOOST_GOOD_TIMEOUT_DEF = 32'd5000;

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        now_ms;
    logic               status_valid;
    logic               main_present;
    logic signed [15:0] vcap_mv;
    logic               charge_fault;
    logic               boost_good;
    logic               host_pong;
    logic               shutdown_ack;
    logic               final_ready;
    logic [31:0]        action_id;
    logic               success;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  phase;
    logic [3:0]  pending_action;
    logic [31:0] pending_id;
    logic [16:0] issue_bits;
    logic [1:0]  shutdown_reason;
    logic        maintenance;
    logic        charge_expected;
    logic        backup_armed;
    logic        host_enabled;
    logic [31:0] shutdown_remaining_ms;
  } out_t;

  typedef struct packed {
    logic [31:0] shutdown_window_ms;
    logic [31:0] action_timeout_ms;
    logic [31:0] charge_time_limit_ms;
    logic [31:0] no_rise_window_ms;
    logic [14:0] max_voltage_mv;
    logic [14:0] target_voltage_mv;
    logic [14:0] rise_step_mv;
    logic [14:0] backup_arm_mv;
  } cfg_t;

  typedef struct packed {
    logic               started;
    logic [2:0]         phase;
    logic [3:0]         pkind;
    logic [31:0]        pid;
    logic [31:0]        nid;
    logic               done_flag;
    logic               done_ok;
    logic [31:0]        t_phase;
    logic [31:0]        t_pending;
    logic [31:0]        t_charge;
    logic [31:0]        t_progress;
    logic [31:0]        t_shutdown;
    logic signed [15:0] progress_mv;
    logic [1:0]         reason;
    logic [16:0]        issues;
    logic               prepared;
    logic               enable_tried;
    logic               stop_needed;
    logic               stop_tried;
    logic               arm_tried;
    logic               host_tried;
    logic               ping_tried;
    logic               charge_expected;
    logic               maintenance;
    logic               backup_armed;
    logic               host_enabled;
  } state_t;

endpackage

/* hdl/bps_step.sv */
module bps_step #(
  parameter int unsigned SETTLING_MS        = bps_pkg::SETTLING_MS_DEF,
  parameter int unsigned PREPARE_TIMEOUT_MS = bps_pkg::PREPARE_TIMEOUT_MS_DEF,
  parameter int unsigned BOOST_GOOD_TIMEOUT = bps_pkg::BOOST_GOOD_TIMEOUT_DEF
) (
  input  bps_pkg::state_t st_i,
  input  bps_pkg::cfg_t   cfg_i,
  input  bps_pkg::in_t    item_i,
  output bps_pkg::state_t st_o,
  output bps_pkg::out_t   res_o
);

  function automatic bps_pkg::state_t clr_pend(bps_pkg::state_t s);
    s.pkind     = bps_pkg::AC_NONE;
    s.pid       = '0;
    s.done_flag = 1'b0;
    s.done_ok   = 1'b0;
    return s;
  endfunction

  function automatic bps_pkg::state_t issue(bps_pkg::state_t s, logic [3:0] kind,
                                            logic [31:0] now);
    s = clr_pend(s);
    s.nid = s.nid + 32'd1;
    if (s.nid == '0) s.nid = 32'd1;
    s.pkind     = kind;
    s.pid       = s.nid;
    s.t_pending = now;
    return s;
  endfunction

  function automatic bps_pkg::state_t leave_chg(bps_pkg::state_t s, logic [16:0] bit_m);
    s.issues = s.issues | bit_m;
    if (s.pkind == bps_pkg::AC_HOST) s.host_tried = 1'b0;
    if (s.pkind == bps_pkg::AC_PING) s.ping_tried = 1'b0;
    if (s.pkind == bps_pkg::AC_ARM) s.arm_tried = 1'b0;
    s = clr_pend(s);
    if (s.phase == bps_pkg::PH_PREP || s.phase == bps_pkg::PH_CHARGE)
      s.phase = bps_pkg::PH_HOST;
    s.charge_expected = 1'b0;
    s.maintenance     = 1'b0;
    s.stop_needed     = 1'b1;
    s.stop_tried      = 1'b0;
    return s;
  endfunction

  function automatic bps_pkg::state_t start_sd(bps_pkg::state_t s, logic [31:0] now,
                                               logic [1:0] why);
    s = clr_pend(s);
    s.phase           = bps_pkg::PH_SDW;
    s.reason          = why;
    s.t_shutdown      = now;
    s.charge_expected = 1'b0;
    s.maintenance     = 1'b0;
    s = issue(s, bps_pkg::AC_SDREQ, now);
    return s;
  endfunction

  function automatic bps_pkg::state_t finish(bps_pkg::state_t s, logic ok, logic [31:0] now,
                                             logic signed [15:0] vcap);
    logic [3:0] kind;
    kind = s.pkind;
    s = clr_pend(s);
    case (kind)
      bps_pkg::AC_PREP: begin
        if (!ok) s = leave_chg(s, bps_pkg::IS_PREPF);
        else begin
          s.prepared = 1'b1;
          s.t_phase  = now;
        end
      end
      bps_pkg::AC_ENCH: begin
        if (!ok) s = leave_chg(s, bps_pkg::IS_ENF);
        else begin
          s.phase           = bps_pkg::PH_CHARGE;
          s.charge_expected = 1'b1;
          s.t_charge        = now;
          s.t_progress      = now;
          s.progress_mv     = vcap;
        end
      end
      bps_pkg::AC_STOP: begin
        if (!ok) s.issues = s.issues | bps_pkg::IS_STOPF;
        s.stop_needed = 1'b0;
      end
      bps_pkg::AC_ARM: begin
        s.backup_armed = ok;
        if (!ok) s.issues = s.issues | bps_pkg::IS_ARMF;
      end
      bps_pkg::AC_HOST: begin
        s.host_enabled = ok;
        if (!ok) s.issues = s.issues | bps_pkg::IS_HOSTF;
      end
      bps_pkg::AC_PING: begin
        if (!ok) s.issues = s.issues | bps_pkg::IS_PINGF;
        s.phase = bps_pkg::PH_RUN;
      end
      bps_pkg::AC_SDREQ: if (!ok) s.issues = s.issues | bps_pkg::IS_SDREQF;
      bps_pkg::AC_CUT:   if (!ok) s.issues = s.issues | bps_pkg::IS_OFFF;
      default: ;
    endcase
    return s;
  endfunction

  // voltages widened to a common signed width
  logic signed [17:0] vcap_w, max_w, tgt_w, arm_w, rise_thr;
  logic [31:0] now, el_sd;
  logic        sv, mainp, vok, bgood;

  assign now    = item_i.now_ms;
  assign sv     = item_i.status_valid;
  assign mainp  = item_i.main_present;
  assign bgood  = item_i.boost_good;
  assign vok    = !item_i.vcap_mv[15];
  assign vcap_w = 18'(item_i.vcap_mv);
  assign max_w  = signed'({3'b000, cfg_i.max_voltage_mv});
  assign tgt_w  = signed'({3'b000, cfg_i.target_voltage_mv});
  assign arm_w  = signed'({3'b000, cfg_i.backup_arm_mv});
  assign rise_thr = 18'(st_i.progress_mv) + signed'({3'b000, cfg_i.rise_step_mv});

  always_comb begin
    bps_pkg::state_t s;
    logic go;
    logic acc;
    logic [31:0] tmo;
    s   = st_i;
    go  = 1'b1;
    acc = 1'b0;
    tmo = '0;
    el_sd = '0;
    case (item_i.op)
      bps_pkg::OP_TICK: begin
        if (s.started) begin
          if (s.phase == bps_pkg::PH_OFF) begin
            if (s.done_flag) s = finish(s, s.done_ok, now, item_i.vcap_mv);
          end else begin
            if (!sv) s.issues = s.issues | bps_pkg::IS_STATUS;
            if (sv && !vok) s.issues = s.issues | bps_pkg::IS_VOLT;
            if (s.phase == bps_pkg::PH_SETTLE) begin
              if ((now - s.t_phase) < SETTLING_MS) go = 1'b0;
              else begin
                s.phase   = bps_pkg::PH_PREP;
                s.t_phase = now;
                if (sv && !mainp) s.issues = s.issues | bps_pkg::IS_NOMAIN;
              end
            end
            if (go) begin
              if (s.phase != bps_pkg::PH_SDW && sv && !mainp)
                s = start_sd(s, now, bps_pkg::RS_MAIN);
              if (s.phase == bps_pkg::PH_SDW &&
                  (now - s.t_shutdown) >= cfg_i.shutdown_window_ms) begin
                s.phase = bps_pkg::PH_OFF;
                s = issue(s, bps_pkg::AC_CUT, now);
                go = 1'b0;
              end
            end
            if (go) begin
              tmo = (s.pkind == bps_pkg::AC_PREP) ? PREPARE_TIMEOUT_MS
                                                  : cfg_i.action_timeout_ms;
              if (s.done_flag) s = finish(s, s.done_ok, now, item_i.vcap_mv);
              else if (s.pkind != bps_pkg::AC_NONE && (now - s.t_pending) >= tmo) begin
                s.issues = s.issues | bps_pkg::IS_TIMEOUT;
                s = finish(s, 1'b0, now, item_i.vcap_mv);
              end
              if (s.phase == bps_pkg::PH_SDW) go = 1'b0;
            end
            if (go) begin
              if ((s.phase == bps_pkg::PH_PREP && s.prepared) ||
                  s.phase == bps_pkg::PH_CHARGE || s.charge_expected) begin
                if (!sv) s = leave_chg(s, bps_pkg::IS_STATUS);
                else if (!vok) s = leave_chg(s, bps_pkg::IS_VOLT);
                else if (vcap_w >= max_w) s = leave_chg(s, bps_pkg::IS_OVERV);
                else if ((s.prepared || s.phase == bps_pkg::PH_CHARGE) &&
                         item_i.charge_fault)
                  s = leave_chg(s, bps_pkg::IS_CHFAULT);
                else if (s.charge_expected && !bgood)
                  s = leave_chg(s, bps_pkg::IS_CHFAULT);
                else if (s.phase == bps_pkg::PH_CHARGE && vcap_w > tgt_w) begin
                  s.maintenance = 1'b1;
                  s.phase       = bps_pkg::PH_HOST;
                end
              end
              if (s.phase == bps_pkg::PH_CHARGE) begin
                if ((now - s.t_charge) >= cfg_i.charge_time_limit_ms)
                  s = leave_chg(s, bps_pkg::IS_TLIMIT);
                else begin
                  if (vcap_w >= rise_thr) begin
                    s.progress_mv = item_i.vcap_mv;
                    s.t_progress  = now;
                  end
                  if ((now - s.t_progress) >= cfg_i.no_rise_window_ms)
                    s = leave_chg(s, bps_pkg::IS_NORISE);
                end
              end
              if (s.pkind != bps_pkg::AC_NONE) go = 1'b0;
            end
            if (go) begin
              if ((s.phase == bps_pkg::PH_HOST || s.phase == bps_pkg::PH_RUN) &&
                  s.stop_needed && !s.stop_tried) begin
                s.stop_tried = 1'b1;
                s = issue(s, bps_pkg::AC_STOP, now);
              end else if ((s.phase == bps_pkg::PH_CHARGE || s.phase == bps_pkg::PH_HOST ||
                            s.phase == bps_pkg::PH_RUN) && !s.arm_tried && sv && mainp &&
                           vok && vcap_w >= arm_w && vcap_w <= max_w) begin
                s.arm_tried = 1'b1;
                s = issue(s, bps_pkg::AC_ARM, now);
              end else if (s.phase == bps_pkg::PH_PREP) begin
                if (!s.prepared) s = issue(s, bps_pkg::AC_PREP, now);
                else if (bgood && !s.enable_tried) begin
                  s.enable_tried = 1'b1;
                  s = issue(s, bps_pkg::AC_ENCH, now);
                end else if ((now - s.t_phase) >= BOOST_GOOD_TIMEOUT) begin
                  s = leave_chg(s, bps_pkg::IS_BOOSTTO);
                  s.stop_tried = 1'b1;
                  s = issue(s, bps_pkg::AC_STOP, now);
                end
              end else if (s.phase == bps_pkg::PH_HOST) begin
                if (!s.host_tried) begin
                  s.host_tried = 1'b1;
                  s = issue(s, bps_pkg::AC_HOST, now);
                end else if (!s.ping_tried) begin
                  s.ping_tried = 1'b1;
                  s = issue(s, bps_pkg::AC_PING, now);
                end
              end
            end
          end
        end
      end
      bps_pkg::OP_DONE: begin
        if (s.pkind != bps_pkg::AC_NONE && s.pid == item_i.action_id && !s.done_flag) begin
          s.done_flag = 1'b1;
          s.done_ok   = item_i.success;
          acc         = 1'b1;
        end
      end
      bps_pkg::OP_REBOOT: begin
        if (s.started && s.phase != bps_pkg::PH_SDW && s.phase != bps_pkg::PH_OFF) begin
          s = start_sd(s, now, bps_pkg::RS_REBOOT);
          acc = 1'b1;
        end
      end
      default: begin
        s         = '0;
        s.nid     = st_i.nid;
        s.started = 1'b1;
        s.t_phase = now;
      end
    endcase

    st_o = s;
    res_o.accepted        = acc;
    res_o.phase           = s.phase;
    res_o.pending_action  = s.pkind;
    res_o.pending_id      = s.pid;
    res_o.issue_bits      = s.issues;
    res_o.shutdown_reason = s.reason;
    res_o.maintenance     = s.maintenance;
    res_o.charge_expected = s.charge_expected;
    res_o.backup_armed    = s.backup_armed;
    res_o.host_enabled    = s.host_enabled;
    res_o.shutdown_remaining_ms = '0;
    if (s.reason != bps_pkg::RS_NONE && s.phase != bps_pkg::PH_OFF) begin
      el_sd = now - s.t_shutdown;
      res_o.shutdown_remaining_ms = (el_sd >= cfg_i.shutdown_window_ms) ? 32'd0
                                    : cfg_i.shutdown_window_ms - el_sd;
    end
  end

endmodule

/* hdl/backup_power_sequencer.sv */
// channel  | direction | handshake           | payload
// in_      | input     | in_valid/in_stall   | bps_pkg::in_t (op, time, telemetry, completion)
// out_     | output    | out_valid/out_stall | bps_pkg::out_t (snapshot after the op)
// cfg_     | input     | cfg_we              | cfg_addr selects register, cfg_wdata value
//
// one op per cycle sustained while the result is not stalled: an op is held in the input
// register, then the whole sequencer update runs in a single combinational pass into the
// state and result registers, so a result is valid once its op leaves the input register
// rst_n (synchronous) restores power-on state and register defaults
// out_stall holds the result register and, through it, the input register
module backup_power_sequencer #(
  parameter int unsigned SETTLING_MS        = bps_pkg::SETTLING_MS_DEF,
  parameter int unsigned PREPARE_TIMEOUT_MS = bps_pkg::PREPARE_TIMEOUT_MS_DEF,
  parameter int unsigned BOOST_GOOD_TIMEOUT = bps_pkg::BOOST_GOOD_TIMEOUT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bps_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bps_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [31:0]   cfg_wdata
);

  // input register
  logic         item_v_r, item_v_nxt;
  bps_pkg::in_t item_r;

  // sequencer state and configuration
  bps_pkg::state_t state_r, state_nxt;
  bps_pkg::cfg_t   cfg_r, cfg_nxt;

  // result register
  logic          res_v_r, res_v_nxt;
  bps_pkg::out_t res_r, res_nxt;

  logic advance;
  logic in_xfer;

  // the pipeline moves whenever the result slot is empty or being taken
  assign advance  = !res_v_r || !out_stall;
  assign in_stall = item_v_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  assign item_v_nxt = in_xfer ? 1'b1 : (advance ? 1'b0 : item_v_r);
  assign res_v_nxt  = advance ? item_v_r : res_v_r;

  bps_step #(
    .SETTLING_MS       (SETTLING_MS),
    .PREPARE_TIMEOUT_MS(PREPARE_TIMEOUT_MS),
    .BOOST_GOOD_TIMEOUT(BOOST_GOOD_TIMEOUT)
  ) u_step (
    .st_i  (state_r),
    .cfg_i (cfg_r),
    .item_i(item_r),
    .st_o  (state_nxt),
    .res_o (res_nxt)
  );

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        bps_pkg::REG_SD_WINDOW: cfg_nxt.shutdown_window_ms   = cfg_wdata;
        bps_pkg::REG_ACT_TMO:   cfg_nxt.action_timeout_ms    = cfg_wdata;
        bps_pkg::REG_CHG_LIMIT: cfg_nxt.charge_time_limit_ms = cfg_wdata;
        bps_pkg::REG_NO_RISE:   cfg_nxt.no_rise_window_ms    = cfg_wdata;
        bps_pkg::REG_MAX_V:     cfg_nxt.max_voltage_mv       = cfg_wdata[14:0];
        bps_pkg::REG_TARGET_V:  cfg_nxt.target_voltage_mv    = cfg_wdata[14:0];
        bps_pkg::REG_RISE_STEP: cfg_nxt.rise_step_mv         = cfg_wdata[14:0];
        bps_pkg::REG_ARM_V:     cfg_nxt.backup_arm_mv        = cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      res_v_r  <= 1'b0;
      state_r  <= '0;
      cfg_r.shutdown_window_ms   <= 32'd60000;
      cfg_r.action_timeout_ms    <= 32'd5000;
      cfg_r.charge_time_limit_ms <= 32'd7200000;
      cfg_r.no_rise_window_ms    <= 32'd600000;
      cfg_r.max_voltage_mv       <= 15'd21000;
      cfg_r.target_voltage_mv    <= 15'd20000;
      cfg_r.rise_step_mv         <= 15'd500;
      cfg_r.backup_arm_mv        <= 15'd12000;
    end else begin
      item_v_r <= item_v_nxt;
      res_v_r  <= res_v_nxt;
      cfg_r    <= cfg_nxt;
      // state commits only when the held op moves into the result slot
      if (item_v_r && advance) state_r <= state_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) item_r <= in_data;
    if (item_v_r && advance) res_r <= res_nxt;
  end

  assign out_valid = res_v_r;
  assign out_data  = res_r;

endmodule

/* hdl/bps_checker.sv */
module bps_assertions (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_stall,
  input bps_pkg::out_t out_data
);

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an action id is shown exactly when an action is pending
  a_pid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.pending_action == bps_pkg::AC_NONE) ==
                   (out_data.pending_id == 32'd0)))
    else $error("pending id does not match pending action");

  // no countdown without a shutdown reason or once off
  a_remain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.shutdown_reason == bps_pkg::RS_NONE ||
                  out_data.phase == bps_pkg::PH_OFF)
    |-> out_data.shutdown_remaining_ms == 32'd0)
    else $error("remaining time without active shutdown");

  // reset empties the result slot
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind backup_power_sequencer bps_assertions u_bps_assertions (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

/* verif/bps_checker.sv */
`timescale 1ns / 1ps

module bps_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  bps_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  bps_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [31:0]   cfg_wdata,
  output int            fail_count,
  output int            waiting
);

  // register copies
  logic [31:0] sd_window, act_tmo, chg_limit, norise_window;
  int          v_max, v_target, v_step, v_arm;

  // sequencer state
  logic        running;
  logic [2:0]  ph;
  logic [3:0]  act_kind;
  logic [31:0] act_id, id_ctr;
  logic        done_held, done_ok;
  logic [31:0] t_ph, t_act, t_chg, t_rise, t_sd;
  int          rise_mark;
  logic [1:0]  sd_why;
  logic [16:0] issues;
  logic        prepared, enable_tried, stop_needed, stop_tried, arm_tried;
  logic        host_tried, ping_tried, chg_on, maint, armed, host_on;

  bps_pkg::out_t snapshots[$];
  int            errs = 0;

  assign fail_count = errs;

  function void clear_seq();
    running = 0; ph = bps_pkg::PH_SETTLE; act_kind = bps_pkg::AC_NONE; act_id = '0;
    done_held = 0; done_ok = 0;
    t_ph = '0; t_act = '0; t_chg = '0; t_rise = '0; t_sd = '0;
    rise_mark = 0; sd_why = bps_pkg::RS_NONE; issues = '0;
    prepared = 0; enable_tried = 0; stop_needed = 0; stop_tried = 0; arm_tried = 0;
    host_tried = 0; ping_tried = 0; chg_on = 0; maint = 0; armed = 0; host_on = 0;
  endfunction

  function void reset_seq();
    clear_seq();
    id_ctr = '0;
    sd_window = 32'd60000; act_tmo = 32'd5000;
    chg_limit = 32'd7200000; norise_window = 32'd600000;
    v_max = 21000; v_target = 20000; v_step = 500; v_arm = 12000;
    snapshots.delete();
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      bps_pkg::REG_SD_WINDOW: sd_window = val;
      bps_pkg::REG_ACT_TMO:   act_tmo = val;
      bps_pkg::REG_CHG_LIMIT: chg_limit = val;
      bps_pkg::REG_NO_RISE:   norise_window = val;
      bps_pkg::REG_MAX_V:     v_max = int'(val[14:0]);
      bps_pkg::REG_TARGET_V:  v_target = int'(val[14:0]);
      bps_pkg::REG_RISE_STEP: v_step = int'(val[14:0]);
      default:                v_arm = int'(val[14:0]);
    endcase
  endfunction

  function void drop_action();
    act_kind = bps_pkg::AC_NONE; act_id = '0; done_held = 0; done_ok = 0;
  endfunction

  function void launch(logic [3:0] kind, logic [31:0] now);
    drop_action();
    id_ctr = id_ctr + 1;
    if (id_ctr == 0) id_ctr = 1;
    act_kind = kind; act_id = id_ctr; t_act = now;
  endfunction

  // give up on charging and arrange for the charger to be stopped
  function void abort_charge(logic [16:0] why);
    issues |= why;
    if (act_kind == bps_pkg::AC_HOST) host_tried = 0;
    if (act_kind == bps_pkg::AC_PING) ping_tried = 0;
    if (act_kind == bps_pkg::AC_ARM) arm_tried = 0;
    drop_action();
    if (ph == bps_pkg::PH_PREP || ph == bps_pkg::PH_CHARGE) ph = bps_pkg::PH_HOST;
    chg_on = 0; maint = 0; stop_needed = 1; stop_tried = 0;
  endfunction

  function void enter_shutdown(logic [31:0] now, logic [1:0] why);
    drop_action();
    ph = bps_pkg::PH_SDW; sd_why = why; t_sd = now; chg_on = 0; maint = 0;
    launch(bps_pkg::AC_SDREQ, now);
  endfunction

  function void close_action(logic ok, logic [31:0] now, int v);
    logic [3:0] kind;
    kind = act_kind;
    drop_action();
    case (kind)
      bps_pkg::AC_PREP: if (!ok) abort_charge(bps_pkg::IS_PREPF); else begin
        prepared = 1; t_ph = now;
      end
      bps_pkg::AC_ENCH: if (!ok) abort_charge(bps_pkg::IS_ENF); else begin
        ph = bps_pkg::PH_CHARGE; chg_on = 1; t_chg = now; t_rise = now; rise_mark = v;
      end
      bps_pkg::AC_STOP: begin
        if (!ok) issues |= bps_pkg::IS_STOPF;
        stop_needed = 0;
      end
      bps_pkg::AC_ARM: begin
        armed = ok;
        if (!ok) issues |= bps_pkg::IS_ARMF;
      end
      bps_pkg::AC_HOST: begin
        host_on = ok;
        if (!ok) issues |= bps_pkg::IS_HOSTF;
      end
      bps_pkg::AC_PING: begin
        if (!ok) issues |= bps_pkg::IS_PINGF;
        ph = bps_pkg::PH_RUN;
      end
      bps_pkg::AC_SDREQ: if (!ok) issues |= bps_pkg::IS_SDREQF;
      bps_pkg::AC_CUT:   if (!ok) issues |= bps_pkg::IS_OFFF;
      default: ;
    endcase
  endfunction

  function void tick(bps_pkg::in_t it);
    logic [31:0] now;
    logic        sv, mainp, fault, bgood;
    int          v;
    logic [31:0] limit;
    now = it.now_ms; sv = it.status_valid; mainp = it.main_present;
    fault = it.charge_fault; bgood = it.boost_good; v = it.vcap_mv;
    if (!running) return;
    if (ph == bps_pkg::PH_OFF) begin
      if (done_held) close_action(done_ok, now, v);
      return;
    end
    if (!sv) issues |= bps_pkg::IS_STATUS;
    if (sv && v < 0) issues |= bps_pkg::IS_VOLT;
    if (ph == bps_pkg::PH_SETTLE) begin
      if (32'(now - t_ph) < bps_pkg::SETTLING_MS_DEF) return;
      ph = bps_pkg::PH_PREP; t_ph = now;
      if (sv && !mainp) issues |= bps_pkg::IS_NOMAIN;
    end
    if (ph != bps_pkg::PH_SDW && sv && !mainp) enter_shutdown(now, bps_pkg::RS_MAIN);
    if (ph == bps_pkg::PH_SDW && 32'(now - t_sd) >= sd_window) begin
      ph = bps_pkg::PH_OFF;
      launch(bps_pkg::AC_CUT, now);
      return;
    end
    limit = (act_kind == bps_pkg::AC_PREP) ? bps_pkg::PREPARE_TIMEOUT_MS_DEF : act_tmo;
    if (done_held) close_action(done_ok, now, v);
    else if (act_kind != bps_pkg::AC_NONE && 32'(now - t_act) >= limit) begin
      issues |= bps_pkg::IS_TIMEOUT;
      close_action(1'b0, now, v);
    end
    if (ph == bps_pkg::PH_SDW) return;

    if ((ph == bps_pkg::PH_PREP && prepared) || ph == bps_pkg::PH_CHARGE || chg_on) begin
      if (!sv) abort_charge(bps_pkg::IS_STATUS);
      else if (v < 0) abort_charge(bps_pkg::IS_VOLT);
      else if (v >= v_max) abort_charge(bps_pkg::IS_OVERV);
      else if ((prepared || ph == bps_pkg::PH_CHARGE) && fault)
        abort_charge(bps_pkg::IS_CHFAULT);
      else if (chg_on && !bgood) abort_charge(bps_pkg::IS_CHFAULT);
      else if (ph == bps_pkg::PH_CHARGE && v > v_target) begin
        maint = 1; ph = bps_pkg::PH_HOST;
      end
    end

    if (ph == bps_pkg::PH_CHARGE) begin
      if (32'(now - t_chg) >= chg_limit) abort_charge(bps_pkg::IS_TLIMIT);
      else begin
        if (v >= rise_mark + v_step) begin
          rise_mark = v; t_rise = now;
        end
        if (32'(now - t_rise) >= norise_window) abort_charge(bps_pkg::IS_NORISE);
      end
    end

    if (act_kind != bps_pkg::AC_NONE) return;

    if ((ph == bps_pkg::PH_HOST || ph == bps_pkg::PH_RUN) && stop_needed && !stop_tried) begin
      stop_tried = 1;
      launch(bps_pkg::AC_STOP, now);
      return;
    end
    if ((ph == bps_pkg::PH_CHARGE || ph == bps_pkg::PH_HOST || ph == bps_pkg::PH_RUN) &&
        !arm_tried && sv && mainp && v >= 0 && v >= v_arm && v <= v_max) begin
      arm_tried = 1;
      launch(bps_pkg::AC_ARM, now);
      return;
    end
    if (ph == bps_pkg::PH_PREP) begin
      if (!prepared) launch(bps_pkg::AC_PREP, now);
      else if (bgood && !enable_tried) begin
        enable_tried = 1;
        launch(bps_pkg::AC_ENCH, now);
      end else if (32'(now - t_ph) >= bps_pkg::BOOST_GOOD_TIMEOUT_DEF) begin
        abort_charge(bps_pkg::IS_BOOSTTO);
        stop_tried = 1;
        launch(bps_pkg::AC_STOP, now);
      end
    end else if (ph == bps_pkg::PH_HOST) begin
      if (!host_tried) begin
        host_tried = 1;
        launch(bps_pkg::AC_HOST, now);
      end else if (!ping_tried) begin
        ping_tried = 1;
        launch(bps_pkg::AC_PING, now);
      end
    end
  endfunction

  function bps_pkg::out_t snapshot_after(bps_pkg::in_t it);
    bps_pkg::out_t r;
    logic [31:0]   el;
    r = '0;
    case (it.op)
      bps_pkg::OP_TICK: tick(it);
      bps_pkg::OP_DONE:
        if (act_kind != bps_pkg::AC_NONE && act_id == it.action_id && !done_held) begin
          done_held = 1; done_ok = it.success; r.accepted = 1;
        end
      bps_pkg::OP_REBOOT:
        if (running && ph != bps_pkg::PH_SDW && ph != bps_pkg::PH_OFF) begin
          enter_shutdown(it.now_ms, bps_pkg::RS_REBOOT);
          r.accepted = 1;
        end
      default: begin
        clear_seq();
        running = 1; t_ph = it.now_ms;
      end
    endcase
    if (sd_why != bps_pkg::RS_NONE && ph != bps_pkg::PH_OFF) begin
      el = it.now_ms - t_sd;
      r.shutdown_remaining_ms = (el >= sd_window) ? 32'd0 : sd_window - el;
    end
    r.phase = ph; r.pending_action = act_kind; r.pending_id = act_id;
    r.issue_bits = issues; r.shutdown_reason = sd_why; r.maintenance = maint;
    r.charge_expected = chg_on; r.backup_armed = armed; r.host_enabled = host_on;
    return r;
  endfunction

  function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errs++;
      if (errs <= 10)
        $display("mismatch %s: expected %0h actual %0h at %0t", name, exp_v, act_v, $realtime);
    end
  endfunction

  always @(posedge clk) begin
    bps_pkg::out_t e;
    if (!rst_n) reset_seq();
    else begin
      if (cfg_we) write_reg(cfg_addr, cfg_wdata);
      if (in_valid && !in_stall) snapshots.push_back(snapshot_after(in_data));
      if (out_valid && !out_stall) begin
        if (snapshots.size() == 0) begin
          errs++;
          if (errs <= 10) $display("result with nothing expected at %0t", $realtime);
        end else begin
          e = snapshots.pop_front();
          check_field("accepted", e.accepted, out_data.accepted);
          check_field("phase", e.phase, out_data.phase);
          check_field("pending_action", e.pending_action, out_data.pending_action);
          check_field("pending_id", e.pending_id, out_data.pending_id);
          check_field("issue_bits", e.issue_bits, out_data.issue_bits);
          check_field("shutdown_reason", e.shutdown_reason, out_data.shutdown_reason);
          check_field("maintenance", e.maintenance, out_data.maintenance);
          check_field("charge_expected", e.charge_expected, out_data.charge_expected);
          check_field("backup_armed", e.backup_armed, out_data.backup_armed);
          check_field("host_enabled", e.host_enabled, out_data.host_enabled);
          check_field("shutdown_remaining_ms", e.shutdown_remaining_ms,
                      out_data.shutdown_remaining_ms);
        end
      end
    end
    waiting <= snapshots.size();
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  logic          clk = 0;
  logic          rst_n = 0;
  logic          in_valid = 0;
  logic          in_stall;
  bps_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 0;
  bps_pkg::out_t out_data;
  logic          cfg_we = 0;
  logic [2:0]    cfg_addr = '0;
  logic [31:0]   cfg_wdata = '0;
  int            fail_count;
  int            waiting;

  // stimulus state: running clock in ms, capacitor ramp, last id seen on the result side
  logic [31:0] clock_ms = '0;
  int          ramp = 0;
  logic [31:0] last_pid = '0;
  logic        idle_on = 0;

  always #5 clk = ~clk;

  backup_power_sequencer i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_addr, .cfg_wdata
  );

  bps_checker i_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_addr, .cfg_wdata,
    .fail_count, .waiting
  );

  // receiver back-pressure, independent of valid
  always @(posedge clk) out_stall <= idle_on && ($urandom_range(99) < 35);

  // completions mostly answer the most recently reported pending action
  always @(posedge clk)
    if (out_valid && !out_stall) last_pid <= out_data.pending_id;

  // hard stop in case the pipeline hangs
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // one transfer; random gaps before it while idling is on
  task automatic send(bps_pkg::in_t it);
    while (idle_on && $urandom_range(99) < 35) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid and wait for every outstanding result
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write enable stays high across a burst, set_regs drops it
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we    <= 1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] win, tmo, lim, norise, vmax, vtgt, vstep, varm);
    write_reg(bps_pkg::REG_SD_WINDOW, win);
    write_reg(bps_pkg::REG_ACT_TMO, tmo);
    write_reg(bps_pkg::REG_CHG_LIMIT, lim);
    write_reg(bps_pkg::REG_NO_RISE, norise);
    write_reg(bps_pkg::REG_MAX_V, vmax);
    write_reg(bps_pkg::REG_TARGET_V, vtgt);
    write_reg(bps_pkg::REG_RISE_STEP, vstep);
    write_reg(bps_pkg::REG_ARM_V, varm);
    cfg_we <= 0;
  endtask

  // random fill of every field
  function automatic bps_pkg::in_t rand_fill();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return bps_pkg::in_t'(raw[$bits(bps_pkg::in_t)-1:0]);
  endfunction

  // unused bits random, then telemetry following a slowly charging capacitor
  function automatic bps_pkg::in_t tick_item();
    bps_pkg::in_t it;
    int           r;
    it = rand_fill();
    r = $urandom_range(99);
    if (r < 3) clock_ms = clock_ms;
    else if (r < 8) clock_ms = clock_ms + $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 2500);
    ramp += $urandom_range(0, 700);
    if (ramp > 23500) ramp = $urandom_range(0, 20000);
    it.op = bps_pkg::OP_TICK;
    it.now_ms = clock_ms;
    it.status_valid = ($urandom_range(99) < 97);
    it.main_present = ($urandom_range(99) < 98);
    it.vcap_mv = ($urandom_range(99) < 4) ? 16'($urandom) : 16'(ramp);
    it.charge_fault = ($urandom_range(99) < 4);
    it.boost_good = ($urandom_range(99) < 92);
    return it;
  endfunction

  function automatic bps_pkg::in_t done_item(logic ok);
    bps_pkg::in_t it;
    int           r;
    it = rand_fill();
    r = $urandom_range(99);
    it.op = bps_pkg::OP_DONE;
    it.action_id = (r < 85) ? last_pid : (r < 90) ? last_pid + 1 : $urandom;
    it.success = ok;
    return it;
  endfunction

  function automatic bps_pkg::in_t op_item(logic [1:0] op);
    bps_pkg::in_t it;
    it = rand_fill();
    it.op = op;
    it.now_ms = clock_ms;
    if (op == bps_pkg::OP_BEGIN) ramp = $urandom_range(0, 15000);
    return it;
  endfunction

  task automatic random_items(int count);
    int r;
    send(op_item(bps_pkg::OP_BEGIN));
    repeat (count) begin
      r = $urandom_range(199);
      if (r < 140) send(tick_item());
      else if (r < 194) send(done_item($urandom_range(99) < 88));
      else if (r < 197) send(op_item(bps_pkg::OP_REBOOT));
      else send(op_item(bps_pkg::OP_BEGIN));
    end
  endtask

  initial begin
    bps_pkg::in_t it;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: defaults, ops before begin, wrap of time, field extremes
    set_regs(60000, 5000, 7200000, 600000, 21000, 20000, 500, 12000);
    it = '0;
    send(it);
    it.op = bps_pkg::OP_DONE;
    send(it);
    it.op = bps_pkg::OP_REBOOT;
    send(it);
    clock_ms = 32'hFFFF_FFF0;
    send(op_item(bps_pkg::OP_BEGIN));
    it = '1;
    it.op = bps_pkg::OP_TICK;
    it.now_ms = 32'd0;
    send(it);
    it = tick_item();
    it.status_valid = 0;
    clock_ms = 32'd20000;
    it.now_ms = clock_ms;
    send(it);
    // well-behaved telemetry with every action completed: walks through prepare into charging
    repeat (7) begin
      it = tick_item();
      it.status_valid = 1; it.main_present = 1; it.charge_fault = 0;
      it.boost_good = 1; it.vcap_mv = 16'sd15000;
      send(it);
      drain();
      it = done_item(1'b1);
      it.action_id = last_pid;
      send(it);
    end
    it = tick_item();
    it.vcap_mv = 16'sh8000;
    send(it);
    it.vcap_mv = 16'sh7FFF;
    send(it);
    send(op_item(bps_pkg::OP_REBOOT));
    clock_ms = clock_ms + 32'd70000;
    it = tick_item();
    it.now_ms = clock_ms;
    send(it);
    drain();

    // random phases over a range of register settings, extremes among them
    for (int p = 1; p <= 7; p++) begin
      drain();
      case (p)
        1: set_regs(20000, 3000, 150000, 25000, 21000, 20000, 500, 12000);
        2: set_regs(0, 0, 0, 0, 0, 0, 0, 0);
        3: set_regs('1, '1, '1, '1, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
        6: set_regs(60000, 5000, 7200000, 600000, 21000, 20000, 500, 12000);
        default: set_regs($urandom_range(0, 80000), $urandom_range(0, 8000),
                          $urandom_range(0, 300000), $urandom_range(0, 60000),
                          $urandom_range(15000, 32767), $urandom_range(10000, 24000),
                          $urandom_range(0, 1500), $urandom_range(0, 20000));
      endcase
      // phase 3 runs with no gaps on either side
      idle_on = (p != 3);
      random_items(280);
    end

    drain();
    if (fail_count == 0 && waiting == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
